[src/cga_pkg.sv]
// ----------------------------------------------------------------------------
// cga_pkg
// Shared types, constants and tables for the CGA composite encoder/decoder.
// ----------------------------------------------------------------------------
package cga_pkg;

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int TAPS        = 7;
    localparam int GAMMA_DEPTH = 256;

    localparam logic [1:0] REG_IQ_GAIN_IN_PHASE   = 2'd0;
    localparam logic [1:0] REG_IQ_GAIN_QUADRATURE = 2'd1;
    localparam logic [1:0] REG_LUMA_CONTRAST      = 2'd2;
    localparam logic [1:0] REG_LUMA_OFFSET        = 2'd3;

    localparam logic signed [12:0] IQ_GAIN_RESET  = 13'sd0;
    localparam logic [15:0]        CONTRAST_RESET = 16'd4389;
    localparam logic signed [23:0] OFFSET_RESET   = -24'sd1473024;

    typedef logic signed [8:0]  sample_t;
    typedef logic signed [12:0] cfg_gain_t;
    typedef logic signed [13:0] gain_t;
    typedef logic signed [21:0] prod_t;
    typedef logic signed [13:0] ysum_t;
    typedef logic signed [26:0] iqsum_t;
    typedef logic signed [31:0] luma_t;
    typedef logic signed [35:0] term_t;
    typedef logic signed [39:0] acc_t;

    typedef struct packed {
        sample_t sample;
        prod_t   inphase;
        prod_t   quadrature;
    } qent_t;

    // burst pattern: hue x chroma phase -> phase level select
    localparam logic [2:0] BURST_TAB [8][4] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd2, 3'd3, 3'd4, 3'd5},
        '{3'd1, 3'd0, 3'd0, 3'd1}, '{3'd5, 3'd2, 3'd3, 3'd4},
        '{3'd3, 3'd4, 3'd5, 3'd2}, '{3'd0, 3'd1, 3'd1, 3'd0},
        '{3'd4, 3'd5, 3'd2, 3'd3}, '{3'd1, 3'd1, 3'd1, 3'd1}
    };

    // rescaled chroma levels; last two entries never selected
    localparam logic signed [9:0] CHROMA_TAB [8] = '{
        10'sd13, 10'sd243, -10'sd34, 10'sd128, 10'sd290, 10'sd128, 10'sd0, 10'sd0
    };

    // by intensity: high - low, and low - 60
    localparam logic [6:0]        LEVEL_SPAN [2] = '{7'd92, 7'd93};
    localparam logic signed [6:0] LEVEL_BASE [2] = '{7'sd11, 7'sd47};

    // largest g with g^10 * 255^9 <= idx^19
    function automatic logic [7:0] gamma_entry(input int unsigned idx);
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [7:0]   g;
        logic [7:0]   cand;
        rhs = 160'd1;
        for (int k = 0; k < 19; k++) begin
            rhs = rhs * 160'(idx);
        end
        g = 8'd0;
        for (int b = 7; b >= 0; b--) begin
            cand = g | 8'(1 << b);
            lhs  = 160'd1;
            for (int k = 0; k < 10; k++) begin
                lhs = lhs * 160'(cand);
            end
            for (int k = 0; k < 9; k++) begin
                lhs = lhs * 160'd255;
            end
            if (lhs <= rhs) begin
                g = cand;
            end
        end
        return g;
    endfunction

endpackage

[src/cga_front.sv]
// ----------------------------------------------------------------------------
// cga_front
// Accepts pixels, builds the composite sample and the I/Q carrier products.
// ----------------------------------------------------------------------------
module cga_front
    import cga_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  cfg_gain_t            iq_gain_in_phase,
    input  cfg_gain_t            iq_gain_quadrature,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qent_t                out_data
);

    logic [3:0]          colour;
    logic [1:0]          chroma_phase;
    logic [1:0]          carrier_phase;
    logic signed [9:0]   chroma;
    logic signed [16:0]  level_prod;
    logic signed [10:0]  sample_wide;
    gain_t               gains [4];
    logic [1:0]          q_phase;
    logic signed [22:0]  i_full;
    logic signed [22:0]  q_full;

    logic    valid_reg;
    sample_t sample_reg;
    gain_t   gain_i_reg;
    gain_t   gain_q_reg;

    assign colour        = s_axis_tdata[3:0];
    assign chroma_phase  = s_axis_tdata[5:4];
    assign carrier_phase = s_axis_tdata[7:6];

    assign chroma      = CHROMA_TAB[BURST_TAB[colour[2:0]][chroma_phase]];
    assign level_prod  = 17'(chroma) * 17'($signed({1'b0, LEVEL_SPAN[colour[3]]}));
    assign sample_wide = 11'(level_prod >>> 8) + 11'(LEVEL_BASE[colour[3]]);

    assign gains[0] = gain_t'(iq_gain_in_phase);
    assign gains[1] = gain_t'(iq_gain_quadrature);
    assign gains[2] = -gain_t'(iq_gain_in_phase);
    assign gains[3] = -gain_t'(iq_gain_quadrature);
    assign q_phase  = carrier_phase + 2'd3;

    assign s_axis_tready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            sample_reg <= sample_wide[8:0];
            gain_i_reg <= gains[carrier_phase];
            gain_q_reg <= gains[q_phase];
        end
    end

    assign i_full = 23'(sample_reg) * 23'(gain_i_reg);
    assign q_full = 23'(sample_reg) * 23'(gain_q_reg);

    assign out_valid           = valid_reg;
    assign out_data.sample     = sample_reg;
    assign out_data.inphase    = i_full[21:0];
    assign out_data.quadrature = q_full[21:0];

endmodule

[src/cga_queue.sv]
// ----------------------------------------------------------------------------
// cga_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module cga_queue
    import cga_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  qent_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output qent_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    qent_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[src/cga_back.sv]
// ----------------------------------------------------------------------------
// cga_back
// YIQ low-pass filter, contrast/brightness, YIQ to RGB, clamp and gamma.
// ----------------------------------------------------------------------------
module cga_back
    import cga_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qent_t                 in_data,
    input  logic [15:0]           luma_contrast,
    input  logic signed [23:0]    luma_offset,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    function automatic logic [7:0] clamp_channel(input acc_t v);
        if (v[39]) begin
            return 8'd0;
        end else if (v[38:24] != '0) begin
            return 8'd255;
        end
        return v[23:16];
    endfunction

    logic [7:0] gamma_rom [GAMMA_DEPTH];

    for (genvar gi = 0; gi < GAMMA_DEPTH; gi++) begin : g_gamma
        localparam logic [7:0] ENTRY = gamma_entry(unsigned'(gi));
        assign gamma_rom[gi] = ENTRY;
    end

    logic en;

    sample_t luma_hist_reg [TAPS];
    prod_t   i_hist_reg    [TAPS];
    prod_t   q_hist_reg    [TAPS];

    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    sample_t s1_reg, s2_reg, s3_reg, s4_reg, m_sample_reg;

    ysum_t  ysum_reg;
    iqsum_t isum_reg;
    iqsum_t qsum_reg;
    ysum_t  ysum;
    iqsum_t isum;
    iqsum_t qsum;

    logic signed [30:0] luma_mul;
    luma_t luma_reg;
    term_t ri_reg, rq_reg, gi_reg, gq_reg, bi_reg, bq_reg;

    acc_t r_acc, g_acc, b_acc;
    logic [7:0] r_idx_reg, g_idx_reg, b_idx_reg;
    logic [7:0] m_red_reg, m_green_reg, m_blue_reg;

    assign en       = !m_valid_reg || m_axis_tready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                luma_hist_reg[k] <= '0;
                i_hist_reg[k]    <= '0;
                q_hist_reg[k]    <= '0;
            end
        end else if (en) begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
            if (in_valid) begin
                for (int k = TAPS - 1; k > 0; k--) begin
                    luma_hist_reg[k] <= luma_hist_reg[k-1];
                    i_hist_reg[k]    <= i_hist_reg[k-1];
                    q_hist_reg[k]    <= q_hist_reg[k-1];
                end
                luma_hist_reg[0] <= in_data.sample;
                i_hist_reg[0]    <= in_data.inphase;
                q_hist_reg[0]    <= in_data.quadrature;
            end
        end
    end

    // kernel 1,4,7,8,7,4,1
    always_comb begin
        ysum = ysum_t'(luma_hist_reg[0]) + ysum_t'(luma_hist_reg[6])
             + ((ysum_t'(luma_hist_reg[1]) + ysum_t'(luma_hist_reg[5])) <<< 2)
             + ((ysum_t'(luma_hist_reg[2]) + ysum_t'(luma_hist_reg[4])) * 14'sd7)
             + (ysum_t'(luma_hist_reg[3]) <<< 3);
        isum = iqsum_t'(i_hist_reg[0]) + iqsum_t'(i_hist_reg[6])
             + ((iqsum_t'(i_hist_reg[1]) + iqsum_t'(i_hist_reg[5])) <<< 2)
             + ((iqsum_t'(i_hist_reg[2]) + iqsum_t'(i_hist_reg[4])) * 27'sd7)
             + (iqsum_t'(i_hist_reg[3]) <<< 3);
        qsum = iqsum_t'(q_hist_reg[0]) + iqsum_t'(q_hist_reg[6])
             + ((iqsum_t'(q_hist_reg[1]) + iqsum_t'(q_hist_reg[5])) <<< 2)
             + ((iqsum_t'(q_hist_reg[2]) + iqsum_t'(q_hist_reg[4])) * 27'sd7)
             + (iqsum_t'(q_hist_reg[3]) <<< 3);
    end

    assign luma_mul = 31'(ysum_reg) * 31'($signed({1'b0, luma_contrast}));

    always_comb begin
        r_acc = acc_t'(luma_reg) + acc_t'(ri_reg) + acc_t'(rq_reg);
        g_acc = acc_t'(luma_reg) - acc_t'(gi_reg) - acc_t'(gq_reg);
        b_acc = acc_t'(luma_reg) - acc_t'(bi_reg) + acc_t'(bq_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg       <= in_data.sample;
            ysum_reg     <= ysum;
            isum_reg     <= isum;
            qsum_reg     <= qsum;
            s2_reg       <= s1_reg;
            luma_reg     <= luma_t'(luma_mul) + luma_t'(luma_offset);
            ri_reg       <= term_t'(isum_reg) * 36'sd243;
            rq_reg       <= term_t'(qsum_reg) * 36'sd160;
            gi_reg       <= term_t'(isum_reg) * 36'sd71;
            gq_reg       <= term_t'(qsum_reg) * 36'sd164;
            bi_reg       <= term_t'(isum_reg) * 36'sd283;
            bq_reg       <= term_t'(qsum_reg) * 36'sd443;
            s3_reg       <= s2_reg;
            r_idx_reg    <= clamp_channel(r_acc);
            g_idx_reg    <= clamp_channel(g_acc);
            b_idx_reg    <= clamp_channel(b_acc);
            s4_reg       <= s3_reg;
            m_red_reg    <= gamma_rom[r_idx_reg];
            m_green_reg  <= gamma_rom[g_idx_reg];
            m_blue_reg   <= gamma_rom[b_idx_reg];
            m_sample_reg <= s4_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_sample_reg, m_blue_reg, m_green_reg, m_red_reg};

endmodule

[src/cga_composite_encode_decode.sv]
// Throughput: one pixel per cycle unless m_axis_tready stalls; the front multiplier stage,
// the request queue and the five-stage back pipeline each advance once per cycle.
// Reset: synchronous, active low; clears the queue, pipeline valids, the Y/I/Q
// filter histories, and loads the register reset values.
// ----------------------------------------------------------------------------
// cga_composite_encode_decode
// CGA RGBI to composite encoder with NTSC decode back to gamma-mapped RGB.
// ----------------------------------------------------------------------------
module cga_composite_encode_decode
    import cga_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // colour[3:0], chroma_phase[5:4],
                                                  // carrier_phase[7:6]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                                  // composite_level[32:24], zero pad
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_gain_t          gain_in_phase_reg;
    cfg_gain_t          gain_quadrature_reg;
    logic [15:0]        contrast_reg;
    logic signed [23:0] offset_reg;

    logic  fq_valid, fq_ready;
    qent_t fq_data;
    logic  qb_valid, qb_ready;
    qent_t qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_in_phase_reg   <= IQ_GAIN_RESET;
            gain_quadrature_reg <= IQ_GAIN_RESET;
            contrast_reg        <= CONTRAST_RESET;
            offset_reg          <= OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IQ_GAIN_IN_PHASE:   gain_in_phase_reg   <= cfg_wdata[12:0];
                REG_IQ_GAIN_QUADRATURE: gain_quadrature_reg <= cfg_wdata[12:0];
                REG_LUMA_CONTRAST:      contrast_reg        <= cfg_wdata[15:0];
                REG_LUMA_OFFSET:        offset_reg          <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cga_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .iq_gain_in_phase   (gain_in_phase_reg),
        .iq_gain_quadrature (gain_quadrature_reg),
        .out_valid          (fq_valid),
        .out_ready          (fq_ready),
        .out_data           (fq_data)
    );

    cga_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    cga_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_data       (qb_data),
        .luma_contrast (contrast_reg),
        .luma_offset   (offset_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// CGA composite encode/decode testbench
// Streams RGBI pixels with their chroma and carrier phases into the block and
// checks each decoded pixel (gamma-mapped RGB and composite level) against a
// cycle-free predictor of the encoder, the I/Q demodulator, the 7-tap
// low-pass filter and the gamma curve. Covers reset values, register
// extremes, random register settings, scanline-shaped traffic, back-pressure
// and full-rate streaming.
// ============================================================================
module testbench;
    import cga_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 20000;

    localparam int BURST_SEL [8][4] = '{
        '{0, 0, 0, 0}, '{2, 3, 4, 5}, '{1, 0, 0, 1}, '{5, 2, 3, 4},
        '{3, 4, 5, 2}, '{0, 1, 1, 0}, '{4, 5, 2, 3}, '{1, 1, 1, 1}
    };
    localparam int CHROMA_LEVEL [6] = '{13, 243, -34, 128, 290, 128};
    localparam int DAC_LEVEL [4]    = '{71, 107, 163, 200};
    localparam int LPF_TAP [7]      = '{1, 4, 7, 8, 7, 4, 1};

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] level;
    } rgb_pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // colour[3:0], chroma_phase[5:4],
                                                // carrier_phase[7:6]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // red[7:0], green[15:8], blue[23:16],
                                                // composite_level[32:24], zero pad
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cga_composite_encode_decode dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // decoder state mirror
    longint     gain_inphase;
    longint     gain_quad;
    longint     contrast;
    longint     brightness;
    longint     y_taps [7];
    longint     i_taps [7];
    longint     q_taps [7];
    logic [7:0] gamma_curve [256];

    rgb_pixel_t expected_pixels [$];
    int         mismatch_count = 0;

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    // largest g with g^10 * 255^9 <= i^19
    function automatic void build_gamma_curve();
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [159:0] scale;
        int           g;
        scale = 160'd1;
        for (int k = 0; k < 9; k++) scale = scale * 160'd255;
        g = 0;
        for (int i = 0; i < 256; i++) begin
            rhs = 160'd1;
            for (int k = 0; k < 19; k++) rhs = rhs * 160'(i);
            while (g < 255) begin
                lhs = scale;
                for (int k = 0; k < 10; k++) lhs = lhs * 160'(g + 1);
                if (lhs <= rhs) g++;
                else break;
            end
            gamma_curve[i] = 8'(g);
        end
    endfunction

    function automatic void reset_decoder_state();
        gain_inphase = 0;
        gain_quad    = 0;
        contrast     = 4389;
        brightness   = -1473024;
        for (int k = 0; k < 7; k++) begin
            y_taps[k] = 0;
            i_taps[k] = 0;
            q_taps[k] = 0;
        end
    endfunction

    function automatic logic [7:0] to_channel(input longint v);
        longint u;
        if (v < 0) return 8'd0;
        u = v >>> 16;
        if (u > 255) u = 255;
        return gamma_curve[u];
    endfunction

    function automatic void decode_pixel(input logic [3:0] colour, input logic [1:0] cph,
                                         input logic [1:0] pph);
        int         chroma;
        int         lo;
        int         hi;
        int         smp;
        longint     gains [4];
        longint     ys;
        longint     is;
        longint     qs;
        longint     y;
        rgb_pixel_t px;
        chroma = CHROMA_LEVEL[BURST_SEL[colour[2:0]][cph]];
        lo     = DAC_LEVEL[colour[3]];
        hi     = DAC_LEVEL[colour[3] + 2];
        smp    = (((hi - lo) * chroma) >>> 8) + lo - 60;
        gains[0] = gain_inphase;
        gains[1] = gain_quad;
        gains[2] = -gain_inphase;
        gains[3] = -gain_quad;
        for (int k = 6; k > 0; k--) begin
            y_taps[k] = y_taps[k-1];
            i_taps[k] = i_taps[k-1];
            q_taps[k] = q_taps[k-1];
        end
        y_taps[0] = smp;
        i_taps[0] = longint'(smp) * gains[pph];
        q_taps[0] = longint'(smp) * gains[(pph + 2'd3) & 2'd3];
        ys = 0;
        is = 0;
        qs = 0;
        for (int k = 0; k < 7; k++) begin
            ys += LPF_TAP[k] * y_taps[k];
            is += LPF_TAP[k] * i_taps[k];
            qs += LPF_TAP[k] * q_taps[k];
        end
        y = ys * contrast + brightness;
        px.red   = to_channel(y + 243 * is + 160 * qs);
        px.green = to_channel(y - 71 * is - 164 * qs);
        px.blue  = to_channel(y - 283 * is + 443 * qs);
        px.level = 9'(smp);
        expected_pixels.push_back(px);
    endfunction

    // four register writes back to back, raw words (upper bits may be junk)
    task automatic load_settings(input logic [CFG_DATA_W-1:0] gi, input logic [CFG_DATA_W-1:0] gq,
                                 input logic [CFG_DATA_W-1:0] ctr,
                                 input logic [CFG_DATA_W-1:0] ofs);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_IQ_GAIN_IN_PHASE;
        cfg_wdata <= gi;
        @(posedge aclk);
        cfg_addr  <= REG_IQ_GAIN_QUADRATURE;
        cfg_wdata <= gq;
        @(posedge aclk);
        cfg_addr  <= REG_LUMA_CONTRAST;
        cfg_wdata <= ctr;
        @(posedge aclk);
        cfg_addr  <= REG_LUMA_OFFSET;
        cfg_wdata <= ofs;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_inphase = longint'($signed(gi[12:0]));
        gain_quad    = longint'($signed(gq[12:0]));
        contrast     = longint'(ctr[15:0]);
        brightness   = longint'($signed(ofs[23:0]));
    endtask

    task automatic send_pixel(input logic [3:0] colour, input logic [1:0] cph,
                              input logic [1:0] pph);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pph, cph, colour};
        do @(posedge aclk); while (!s_axis_tready);
        decode_pixel(colour, cph, pph);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic send_random_pixel();
        send_pixel(4'($urandom), 2'($urandom), 2'($urandom));
    endtask

    // one run of pixels along a line: phases step with x, colours come in runs
    task automatic send_scanline(input int n);
        logic [1:0] skew;
        logic [1:0] x;
        logic [3:0] colour;
        int         run;
        skew = 2'($urandom);
        x    = 2'($urandom);
        run  = 0;
        colour = '0;
        for (int k = 0; k < n; k++) begin
            if (run == 0) begin
                colour = 4'($urandom);
                run    = $urandom_range(1, 8);
            end
            send_pixel(colour, x + skew, x);
            x++;
            run--;
        end
    endtask

    task automatic send_mixed_traffic(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) send_random_pixel();
            end else begin
                len = $urandom_range(8, 32);
                send_scanline(len);
            end
            sent += len;
        end
    endtask

    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] words [4];
        for (int r = 0; r < 2; r++) begin
            case ($urandom_range(0, 3))
                0, 1: words[r] = CFG_DATA_W'($signed($urandom_range(0, 48)) - 24);
                2:    words[r] = CFG_DATA_W'($urandom);
                default: words[r] = $urandom_range(0, 1) ? 24'h000FFF : 24'hFFF000;
            endcase
        end
        words[2] = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(2000, 8000))
                                        : CFG_DATA_W'($urandom);
        words[3] = $urandom_range(0, 1)
                 ? CFG_DATA_W'(-1473024 + $signed($urandom_range(0, 2097152)) - 1048576)
                 : CFG_DATA_W'($urandom);
        load_settings(words[0], words[1], words[2], words[3]);
    endtask

    task automatic test_startup_colours();
        for (int c = 0; c < 16; c++) send_pixel(4'(c), 2'(c), 2'(c + c / 4));
        drain_results();
    endtask

    task automatic test_register_extremes();
        load_settings(24'h000FFF, 24'h001000, 24'h00FFFF, 24'h7FFFFF);
        for (int k = 0; k < 4; k++) send_pixel(4'(k * 5), 2'(k), 2'(3 - k));
        drain_results();
        load_settings(24'hFFF000, 24'hFFEFFF, 24'h000000, 24'h800000);
        for (int k = 0; k < 4; k++) send_pixel(4'(15 - k * 4), 2'(k + 1), 2'(k));
        drain_results();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            randomize_settings();
            send_mixed_traffic(95);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        load_settings(24'h000010, 24'hFFFFF0, 24'd4389, CFG_DATA_W'(-1473024));
        tx_gaps = 1'b0;
        hold_requests <= hold_requests + 1;
        send_mixed_traffic(40);
        tx_gaps = 1'b1;
        drain_results();
    endtask

    task automatic test_drain_pause();
        randomize_settings();
        send_scanline(20);
        s_axis_tvalid <= 1'b0;
        wait (expected_pixels.size() == 0);
        @(posedge aclk);
        send_scanline(20);
        drain_results();
    endtask

    task automatic test_full_rate();
        randomize_settings();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_mixed_traffic(150);
        drain_results();
    endtask

    // receiver: random stall bursts, plus a long hold when requested
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        rgb_pixel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: result with no pending request, actual %h", $time,
                         m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red", want.red, m_axis_tdata[7:0]);
                check_field("green", want.green, m_axis_tdata[15:8]);
                check_field("blue", want.blue, m_axis_tdata[23:16]);
                check_field("composite_level", $signed(want.level),
                            $signed(m_axis_tdata[32:24]));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        build_gamma_curve();
        reset_decoder_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_startup_colours();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_drain_pause();
        test_full_rate();
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
src/cga_pkg.sv
src/cga_front.sv
src/cga_queue.sv
src/cga_back.sv
src/cga_composite_encode_decode.sv
tb/testbench.sv
